### rtl/m3sh_pkg.sv
// shared types and constants of the streaming murmur3 hash block
package m3sh_pkg;

    // murmur3 x86_32 mixing constants
    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0] FULL_BYTES = 3'd4;

    // what a word asks of the back end
    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_TAIL,
        KIND_BLOCK
    } word_kind_t;

    // classified word as it sits in the queue
    typedef struct packed {
        logic [31:0] data;     // masked word
        logic [2:0]  nbytes;   // clamped byte count, 0 to 4
        word_kind_t  kind;
        logic        closing;  // finalize after this word
        logic        early;    // closed by a short non-last word
    } entry_t;

    // seed register write as seen by the back end
    typedef struct packed {
        logic        en;
        logic [31:0] value;
    } seed_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_OUT
    } back_state_t;

endpackage

### rtl/m3sh_front.sv
// front end: clamps the byte count, masks the word and classifies it
module m3sh_front
(
    input  logic [31:0]     word,
    input  logic [2:0]      valid_bytes,
    input  logic            last,
    output m3sh_pkg::entry_t entry
);

    logic [2:0]  nbytes;
    logic [31:0] mask;
    logic        full_word;

    always_comb
    begin
        // counts above four mean a full word
        if (valid_bytes inside {[3'd4:3'd7]})
        begin
            nbytes = m3sh_pkg::FULL_BYTES;
        end
        else
        begin
            nbytes = valid_bytes;
        end

        case (nbytes)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase

        full_word = (nbytes == m3sh_pkg::FULL_BYTES);

        entry.data    = word & mask;
        entry.nbytes  = nbytes;
        entry.closing = last || !full_word;
        entry.early   = !last && !full_word;

        if (full_word)
        begin
            entry.kind = m3sh_pkg::KIND_BLOCK;
        end
        else if (nbytes == 3'd0)
        begin
            entry.kind = m3sh_pkg::KIND_EMPTY;
        end
        else
        begin
            entry.kind = m3sh_pkg::KIND_TAIL;
        end
    end

endmodule

### rtl/m3sh_fifo.sv
// short queue of classified words between front and back end
module m3sh_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  m3sh_pkg::entry_t push_data,
    input  logic             pop,
    output m3sh_pkg::entry_t head,
    output logic             not_empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    m3sh_pkg::entry_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/m3sh_back.sv
// back end: key mix, running hash update, finalization and result register
module m3sh_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  m3sh_pkg::seed_wr_t seed_wr,
    input  logic [31:0]        seed_cur,
    input  m3sh_pkg::entry_t   head,
    input  logic               head_valid,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [31:0]        hash,
    output logic               ended_early
);

    m3sh_pkg::back_state_t state_reg;
    m3sh_pkg::back_state_t state_next;

    m3sh_pkg::entry_t cur_reg;
    m3sh_pkg::entry_t cur_next;
    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;
    logic [31:0]      run_reg;
    logic [31:0]      run_next;
    logic [31:0]      total_reg;
    logic [31:0]      total_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_hash_reg;
    logic [31:0]      out_hash_next;
    logic             out_early_reg;
    logic             out_early_next;

    logic [31:0] total_sum;
    logic [31:0] mixed;
    logic [31:0] rot_h;
    logic [31:0] new_h;

    always_comb
    begin
        total_sum = total_reg + {29'd0, cur_reg.nbytes};
        mixed     = run_reg ^ acc_reg;
        rot_h     = {mixed[18:0], mixed[31:19]};
        case (cur_reg.kind)
            m3sh_pkg::KIND_BLOCK: new_h = (rot_h << 2) + rot_h + m3sh_pkg::MIX_ADD;
            m3sh_pkg::KIND_TAIL:  new_h = mixed;
            default:              new_h = run_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        run_next       = run_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_hash_next  = out_hash_reg;
        out_early_next = out_early_reg;
        pop            = 1'b0;

        case (state_reg)
            m3sh_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    acc_next = head.data * m3sh_pkg::MIX_C1;
                    if (head.kind == m3sh_pkg::KIND_EMPTY)
                    begin
                        state_next = m3sh_pkg::ST_MIX;
                    end
                    else
                    begin
                        state_next = m3sh_pkg::ST_KEY2;
                    end
                end
            end
            m3sh_pkg::ST_KEY2:
            begin
                acc_next   = {acc_reg[16:0], acc_reg[31:17]} * m3sh_pkg::MIX_C2;
                state_next = m3sh_pkg::ST_MIX;
            end
            m3sh_pkg::ST_MIX:
            begin
                if (cur_reg.closing)
                begin
                    acc_next   = new_h ^ total_sum;
                    run_next   = seed_cur;
                    total_next = '0;
                    state_next = m3sh_pkg::ST_FIN1;
                end
                else
                begin
                    run_next   = new_h;
                    total_next = total_sum;
                    state_next = m3sh_pkg::ST_IDLE;
                end
            end
            m3sh_pkg::ST_FIN1:
            begin
                acc_next   = (acc_reg ^ (acc_reg >> 16)) * m3sh_pkg::FIN_M1;
                state_next = m3sh_pkg::ST_FIN2;
            end
            m3sh_pkg::ST_FIN2:
            begin
                acc_next   = (acc_reg ^ (acc_reg >> 13)) * m3sh_pkg::FIN_M2;
                state_next = m3sh_pkg::ST_OUT;
            end
            m3sh_pkg::ST_OUT:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = acc_reg ^ (acc_reg >> 16);
                    out_early_next = cur_reg.early;
                    state_next     = m3sh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = m3sh_pkg::ST_IDLE;
            end
        endcase

        // new seed reloads the hash only at message start
        if (seed_wr.en && (total_reg == '0))
        begin
            run_next = seed_wr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= m3sh_pkg::ST_IDLE;
            run_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        acc_reg       <= acc_next;
        out_hash_reg  <= out_hash_next;
        out_early_reg <= out_early_next;
    end

    assign res_valid   = out_valid_reg;
    assign hash        = out_hash_reg;
    assign ended_early = out_early_reg;

endmodule

### rtl/murmur3_stream_hash_top.sv
// top level of the streaming murmur3 x86_32 hash block
// A message streams in as little-endian 32-bit words, one word per handshake on the msg
// channel, first byte in bits 7:0. Each word runs through the back end's chain of dependent,
// individually registered steps: two key-mix multiplies (the second skipped for a word with no
// bytes) and the running-hash update; a full word (valid_bytes of 4 or more) that is not last
// ends there, while a word that closes the message goes on through two avalanche multiplies
// before its hash is loaded into the result register, which may first wait on res_stall.
// A queue of QUEUE_DEPTH words sits between the word classifier and the back end, so msg_stall
// goes high only once that queue is full; the result register lets the next message start
// while a finished hash still waits to be taken. Any word with last set, or any short word,
// closes the message; a short word without last sets ended_early. Words with zero bytes and last
// set finalize what has been absorbed (an empty message hashes to the finalized seed). The seed
// register is written through the cfg channel, which is always ready; a write is meant to happen
// only while the block is idle, and takes effect from the next message on.
module murmur3_stream_hash_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // message word channel
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [31:0] word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] hash,
    output logic        ended_early,
    // seed write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] seed
);

    logic [31:0] seed_reg;

    m3sh_pkg::entry_t   front_entry;
    m3sh_pkg::entry_t   head;
    m3sh_pkg::seed_wr_t seed_wr;
    logic               head_valid;
    logic               pop;
    logic               queue_full;
    logic               msg_push;

    // seed write port never pushes back
    assign cfg_ready     = 1'b1;
    assign seed_wr.en    = cfg_valid && cfg_ready;
    assign seed_wr.value = seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr.en)
        begin
            seed_reg <= seed;
        end
    end

    // word is taken whenever the queue has room
    assign msg_stall = queue_full;
    assign msg_push  = msg_valid && !msg_stall;

    m3sh_front u_front
    (
        .word        (word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .entry       (front_entry)
    );

    m3sh_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (msg_push),
        .push_data (front_entry),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // mixing, finalization and result register
    m3sh_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_wr     (seed_wr),
        .seed_cur    (seed_reg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .hash        (hash),
        .ended_early (ended_early)
    );

endmodule

### rtl/m3sh_checker.sv
// port-level checks of the streaming murmur3 hash block and their binding
module m3sh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] hash,
    input logic        ended_early,
    input logic        cfg_ready
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(hash) && $stable(ended_early))
        else $error("result changed while stalled");

    // the queue can only fill up right after taking a word
    a_stall_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_stall) |-> $past(msg_valid && !msg_stall))
        else $error("msg_stall rose with no word taken");

    // seed port never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind murmur3_stream_hash_top m3sh_checker u_checker (.*);

### bench/testbench.sv
// self-checking bench for the streaming murmur3 hash block, with its own hash predictor
`timescale 1ns / 100ps

module testbench;

    // murmur3 x86_32 constants, kept apart from the package so a wrong constant there shows up
    localparam logic [31:0] HASH_C1   = 32'hcc9e2d51;
    localparam logic [31:0] HASH_C2   = 32'h1b873593;
    localparam logic [31:0] HASH_ADD  = 32'he6546b64;
    localparam logic [31:0] AVAL_M1   = 32'h85ebca6b;
    localparam logic [31:0] AVAL_M2   = 32'hc2b2ae35;
    localparam logic [2:0]  WORD_FULL = 3'd4;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PRESSURE_CYCLES = 400;   // long result hold-off, fills the word queue
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no handshake at all
    localparam int ITEMS_PER_PHASE = 272;
    localparam int NUM_PHASES      = 6;
    localparam int NUM_DIRECTED    = 23;
    localparam int MAX_REPORTS     = 10;

    // one finished hash as the result channel carries it
    typedef struct packed {
        logic [31:0] hash;
        logic        early;
    } digest_t;

    // one row of the directed stimulus; typed rows carry their expected digest
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        closing;
        logic        typed;
        logic [31:0] exp_hash;
        logic        exp_early;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [31:0] word = '0;
    logic [2:0]  valid_bytes = '0;
    logic        last = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [31:0] hash;
    logic        ended_early;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] seed = '0;

    // predictor state: seed register, running hash and byte count of the open message
    logic [31:0] cur_seed = '0;
    logic [31:0] run_hash = '0;
    logic [31:0] byte_count = '0;

    // digests owed by the block, oldest first
    digest_t pending_digests[$];

    int fail_count = 0;
    int phase_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // directed words: empty messages, byte-count extremes, oversized counts, short closes
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // empty message with the reset seed of zero hashes to zero
        '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b0},
        // short word with no bytes at message start: zero hash, closed early
        '{32'hffffffff, 3'd0, 1'b0, 1'b1, 32'h00000000, 1'b1},
        // empty message again, junk in the unused bytes
        '{32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b0},
        '{32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        // bytes beyond the count must not matter
        '{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h12345678, 3'd2, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h80000001, 3'd3, 1'b1, 1'b0, 32'h0, 1'b0},
        // counts of 5 to 7 behave as a full word
        '{32'ha5a5a5a5, 3'd5, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h5a5a5a5a, 3'd6, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hffffffff, 3'd7, 1'b1, 1'b0, 32'h0, 1'b0},
        // short non-last words close the message early
        '{32'hdeadbeef, 3'd1, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h01020304, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'hcafef00d, 3'd2, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h00000001, 3'd3, 1'b0, 1'b0, 32'h0, 1'b0},
        // zero-byte non-last word finalizes what was absorbed
        '{32'h89abcdef, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h76543210, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0, 1'b0},
        // zero-byte last word after a full word
        '{32'h11111111, 3'd4, 1'b0, 1'b0, 32'h0, 1'b0},
        '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0, 1'b0},
        // single-word messages
        '{32'h80000000, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0, 1'b0},
        '{32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    murmur3_stream_hash_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .word        (word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .hash        (hash),
        .ended_early (ended_early),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed        (seed)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- hash predictor

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * HASH_C1;
        t = rotl(t, 15);
        return t * HASH_C2;
    endfunction

    function automatic logic [31:0] fold_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = h ^ scramble_key(k);
        t = rotl(t, 13);
        return t * 32'd5 + HASH_ADD;
    endfunction

    function automatic logic [31:0] avalanche_mix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * AVAL_M1;
        t = t ^ (t >> 13);
        t = t * AVAL_M2;
        return t ^ (t >> 16);
    endfunction

    // absorb one accepted word; returns 1 and the digest when the word closes the message
    function automatic bit absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                                       input logic closing, output digest_t d);
        logic [31:0] h;
        logic [2:0]  n;
        h = run_hash;
        n = (nbytes > WORD_FULL) ? WORD_FULL : nbytes;
        d = '0;
        if (n == WORD_FULL)
        begin
            h = fold_block(h, data);
            byte_count = byte_count + 32'd4;
            if (!closing)
            begin
                run_hash = h;
                return 1'b0;
            end
        end
        else if (n != 3'd0)
        begin
            // tail: key mixed and xored in, no rotate or add on the hash
            h = h ^ scramble_key(data & (32'hffffffff >> (8 * (4 - n))));
            byte_count = byte_count + 32'(n);
        end
        h = h ^ byte_count;
        d.hash = avalanche_mix(h);
        d.early = !closing;
        run_hash = cur_seed;
        byte_count = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- word sender

    // offer one word after a random gap; inputs move on the falling edge only
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic closing, input bit typed, input digest_t typed_d);
        int      gap;
        bit      closes;
        digest_t d;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_valid   <= 1'b1;
        word        <= data;
        valid_bytes <= nbytes;
        last        <= closing;
        // held steady until the block takes it
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        closes = absorb_word(data, nbytes, closing, d);
        if (closes)
            pending_digests.push_back(typed ? typed_d : d);
        phase_items++;
        @(negedge clk);
    endtask

    // one random message: mostly full words and a closing word, some noise
    task automatic send_message();
        int       n_full;
        int       pick;
        logic [2:0] nb;
        logic     lst;
        bit       done;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: any count, any last, until something closes the message
            done = 1'b0;
            while (!done)
            begin
                nb  = 3'($urandom_range(7, 0));
                lst = 1'($urandom_range(1, 0));
                send_word($urandom, nb, lst, 1'b0, '0);
                done = lst || (nb < WORD_FULL);
            end
        end
        else
        begin
            // mostly short messages, a few long ones
            n_full = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(5, 0);
            repeat (n_full)
            begin
                nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : WORD_FULL;
                send_word($urandom, nb, 1'b0, 1'b0, '0);
            end
            if (pick < 22)
                send_word($urandom, 3'($urandom_range(3, 0)), 1'b0, 1'b0, '0);
            else
                send_word($urandom, 3'($urandom_range(7, 0)), 1'b1, 1'b0, '0);
        end
    endtask

    // seed write, only while no message is open
    task automatic write_seed(input logic [31:0] value);
        cfg_valid <= 1'b1;
        seed      <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_seed = value;
        if (byte_count == '0)
            run_hash = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every owed digest in, then let the back end settle
    task automatic wait_drained();
        while (pending_digests.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------- result side

    // result stall: random by mode, or a long hold-off when the sender asks for one
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left  <= PRESSURE_CYCLES - 1;
            res_stall  <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // each taken result against the oldest owed digest, field by field
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_digests.size() == 0)
                note_failure($sformatf("unexpected result hash %08h ended_early %0b",
                                       hash, ended_early));
            else
            begin
                want = pending_digests.pop_front();
                if (hash !== want.hash)
                    note_failure($sformatf("hash mismatch: expected %08h, got %08h",
                                           want.hash, hash));
                if (ended_early !== want.early)
                    note_failure($sformatf("ended_early mismatch: expected %0b, got %0b",
                                           want.early, ended_early));
            end
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (msg_valid && !msg_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        logic [31:0] phase_seed;
        digest_t     typed_d;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words run on the reset seed of zero
        send_idle_pct = 10;
        recv_idle_pct = 62;
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            typed_d.hash  = directed_rows[i].exp_hash;
            typed_d.early = directed_rows[i].exp_early;
            send_word(directed_rows[i].data, directed_rows[i].nbytes, directed_rows[i].closing,
                      directed_rows[i].typed, typed_d);
        end
        msg_valid <= 1'b0;
        wait_drained();

        // random phases: seed extremes and random seeds, three idling modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_seed = 32'hffffffff;
                2: phase_seed = 32'h00000000;
                4: phase_seed = 32'h80000000;
                default: phase_seed = $urandom;
            endcase
            if (p < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 62;
            end
            else if (p < 4)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_seed(phase_seed);
            // long result hold-off while words keep coming, so the queue fills
            if (p == 0 || p == 4)
                hold_asked++;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                send_message();
            msg_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/m3sh_pkg.sv
rtl/m3sh_front.sv
rtl/m3sh_fifo.sv
rtl/m3sh_back.sv
rtl/murmur3_stream_hash_top.sv
rtl/m3sh_checker.sv
bench/testbench.sv
